// ===== rtl/core/iicfp_pkg.sv =====
// shared constants and types for the decimal/decimal/char/hex text field parser
package iicfp_pkg;

    // value accumulator width default
    localparam int VALUE_WIDTH_DEF = 32;

    // result field widths
    localparam int CH_W    = 8;
    localparam int COUNT_W = 3;
    localparam int OUT_W   = 32;
    localparam int PHASE_W = 3;

    // parse phases
    localparam logic [PHASE_W-1:0] PH_SKIP1 = 3'd0;
    localparam logic [PHASE_W-1:0] PH_DEC1  = 3'd1;
    localparam logic [PHASE_W-1:0] PH_SKIP2 = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DEC2  = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SKIPC = 3'd4;
    localparam logic [PHASE_W-1:0] PH_SKIPH = 3'd5;
    localparam logic [PHASE_W-1:0] PH_HEX   = 3'd6;
    localparam logic [PHASE_W-1:0] PH_STOP  = 3'd7;

    // ascii codes
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;
    localparam logic [CH_W-1:0] CH_UF    = 8'h46;
    localparam logic [CH_W-1:0] CH_UX    = 8'h58;
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;
    localparam logic [CH_W-1:0] CH_LF    = 8'h66;
    localparam logic [CH_W-1:0] CH_LX    = 8'h78;

    // per-field control flags; in the hex phase neg marks a taken 0x prefix
    // and saw_zero marks a single leading '0'
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               neg;
        logic               digit_seen;
        logic               saw_zero;
    } t_ctl;

endpackage

// ===== rtl/core/int_int_char_hex_field_parser_top.sv =====
// top level of the decimal/decimal/char/hex text field parser
//
//  channel  direction  handshake           word
//  input    in         i_valid / o_ready   i_ch, one ascii byte
//  result   out        o_valid / i_ready   o_field_count .. o_hex_value
//
// One byte is taken per cycle unless a terminator waits in the input register.
// A byte is held in the input register, then the step logic updates the parse
// state; when a zero byte leaves the input register the result register loads,
// raising o_valid, and the parse state returns to reset. Reset clears the parse
// state and both valid flags. A terminator waits in the input register only while
// the result register is full and i_ready is low, and no byte is taken behind it.
module int_int_char_hex_field_parser_top #(
    parameter int VALUE_WIDTH = iicfp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [iicfp_pkg::CH_W-1:0]          i_ch,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [iicfp_pkg::COUNT_W-1:0]       o_field_count,
    output logic signed [iicfp_pkg::OUT_W-1:0]  o_first_value,
    output logic signed [iicfp_pkg::OUT_W-1:0]  o_second_value,
    output logic [iicfp_pkg::CH_W-1:0]          o_char_value,
    output logic [iicfp_pkg::OUT_W-1:0]         o_hex_value
);
    import iicfp_pkg::*;

    logic                   r_in_valid;
    logic [CH_W-1:0]        r_ch;
    t_ctl                   r_ctl;
    logic [VALUE_WIDTH-1:0] r_accum;
    logic [COUNT_W-1:0]     r_count;
    logic [OUT_W-1:0]       r_first;
    logic [OUT_W-1:0]       r_second;
    logic [CH_W-1:0]        r_char;
    logic                   r_out_valid;
    logic [COUNT_W-1:0]     r_out_count;
    logic [OUT_W-1:0]       r_out_first;
    logic [OUT_W-1:0]       r_out_second;
    logic [CH_W-1:0]        r_out_char;
    logic [OUT_W-1:0]       r_out_hex;

    t_ctl                   n_ctl;
    logic [VALUE_WIDTH-1:0] n_accum;
    logic [COUNT_W-1:0]     n_count;
    logic [OUT_W-1:0]       n_first;
    logic [OUT_W-1:0]       n_second;
    logic [CH_W-1:0]        n_char;

    logic                   is_term;
    logic                   advance;
    logic                   in_fire;

    // handshake: a terminator waits only while the result register is full
    assign is_term = (r_ch == CH_NUL);
    assign advance = r_in_valid && (!is_term || !r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign in_fire = i_valid && o_ready;

    // per-byte next-state logic
    iicfp_step #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_step (
        .i_ch     (r_ch),
        .i_ctl    (r_ctl),
        .i_accum  (r_accum),
        .i_count  (r_count),
        .i_first  (r_first),
        .i_second (r_second),
        .i_char   (r_char),
        .o_ctl    (n_ctl),
        .o_accum  (n_accum),
        .o_count  (n_count),
        .o_first  (n_first),
        .o_second (n_second),
        .o_char   (n_char)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
        if (in_fire) begin
            r_ch <= i_ch;
        end
    end

    // parse state; a terminator returns it to reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl    <= '{phase: PH_SKIP1, default: 1'b0};
            r_accum  <= '0;
            r_count  <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_char   <= '0;
        end else if (advance) begin
            if (is_term) begin
                r_ctl    <= '{phase: PH_SKIP1, default: 1'b0};
                r_accum  <= '0;
                r_count  <= '0;
                r_first  <= '0;
                r_second <= '0;
                r_char   <= '0;
            end else begin
                r_ctl    <= n_ctl;
                r_accum  <= n_accum;
                r_count  <= n_count;
                r_first  <= n_first;
                r_second <= n_second;
                r_char   <= n_char;
            end
        end
    end

    // result register; fields not parsed read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && is_term) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && is_term) begin
            r_out_count  <= n_count;
            r_out_first  <= (n_count >= COUNT_W'(1)) ? n_first : '0;
            r_out_second <= (n_count >= COUNT_W'(2)) ? n_second : '0;
            r_out_char   <= (n_count >= COUNT_W'(3)) ? n_char : '0;
            r_out_hex    <= (n_count >= COUNT_W'(4)) ? OUT_W'(n_accum) : '0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_field_count  = r_out_count;
    assign o_first_value  = signed'(r_out_first);
    assign o_second_value = signed'(r_out_second);
    assign o_char_value   = r_out_char;
    assign o_hex_value    = r_out_hex;

endmodule

// ===== rtl/core/iicfp_step.sv =====
// next-state logic: folds one byte into the parser state
module iicfp_step #(
    parameter int VALUE_WIDTH = iicfp_pkg::VALUE_WIDTH_DEF
) (
    input  logic [iicfp_pkg::CH_W-1:0]    i_ch,
    input  iicfp_pkg::t_ctl               i_ctl,
    input  logic [VALUE_WIDTH-1:0]        i_accum,
    input  logic [iicfp_pkg::COUNT_W-1:0] i_count,
    input  logic [iicfp_pkg::OUT_W-1:0]   i_first,
    input  logic [iicfp_pkg::OUT_W-1:0]   i_second,
    input  logic [iicfp_pkg::CH_W-1:0]    i_char,
    output iicfp_pkg::t_ctl               o_ctl,
    output logic [VALUE_WIDTH-1:0]        o_accum,
    output logic [iicfp_pkg::COUNT_W-1:0] o_count,
    output logic [iicfp_pkg::OUT_W-1:0]   o_first,
    output logic [iicfp_pkg::OUT_W-1:0]   o_second,
    output logic [iicfp_pkg::CH_W-1:0]    o_char
);
    import iicfp_pkg::*;

    logic                   is_dec;
    logic                   is_hex;
    logic [3:0]             dec_d;
    logic [3:0]             hex_d;
    logic                   done;
    logic [PHASE_W-1:0]     ph;
    logic                   neg;
    logic                   dig;
    logic                   sz;
    logic [VALUE_WIDTH-1:0] acc;
    logic [COUNT_W-1:0]     cnt;
    logic [OUT_W-1:0]       first;
    logic [OUT_W-1:0]       second;
    logic [CH_W-1:0]        chr;
    logic [VALUE_WIDTH-1:0] mag;
    logic [OUT_W-1:0]       dec_val;

    // digit classification
    always_comb begin
        is_dec = (i_ch >= CH_ZERO) && (i_ch <= CH_NINE);
        is_hex = is_dec || ((i_ch >= CH_LA) && (i_ch <= CH_LF))
                        || ((i_ch >= CH_UA) && (i_ch <= CH_UF));
        dec_d  = i_ch[3:0];
        hex_d  = is_dec ? i_ch[3:0] : 4'(i_ch[3:0] + 4'd9);
    end

    // phase walk: a byte that ends a field is handled again in the next phase
    always_comb begin
        done   = 1'b0;
        ph     = i_ctl.phase;
        neg    = i_ctl.neg;
        dig    = i_ctl.digit_seen;
        sz     = i_ctl.saw_zero;
        acc    = i_accum;
        cnt    = i_count;
        first  = i_first;
        second = i_second;
        chr    = i_char;
        mag    = '0;
        dec_val = '0;

        // two rounds of skip then decimal cover the end of the first decimal
        for (int k = 0; k < 2; k++) begin
            // skip spaces ahead of a decimal
            if (!done && (ph == PH_SKIP1 || ph == PH_SKIP2)) begin
                if (i_ch == CH_SPACE) begin
                    done = 1'b1;
                end else begin
                    neg = 1'b0;
                    dig = 1'b0;
                    sz  = 1'b0;
                    acc = '0;
                    ph  = (ph == PH_SKIP1) ? PH_DEC1 : PH_DEC2;
                end
            end
            // signed decimal
            if (!done && (ph == PH_DEC1 || ph == PH_DEC2)) begin
                if (i_ch == CH_MINUS && !neg && !dig) begin
                    neg  = 1'b1;
                    done = 1'b1;
                end else if (is_dec) begin
                    acc  = (acc << 3) + (acc << 1) + VALUE_WIDTH'(dec_d);
                    dig  = 1'b1;
                    done = 1'b1;
                end else if (!dig) begin
                    acc  = '0;
                    ph   = PH_STOP;
                    done = 1'b1;
                end else begin
                    mag     = neg ? (~acc + 1'b1) : acc;
                    dec_val = OUT_W'(signed'(mag));
                    if (ph == PH_DEC1) begin
                        first = dec_val;
                        ph    = PH_SKIP2;
                    end else begin
                        second = dec_val;
                        ph     = PH_SKIPC;
                    end
                    cnt = COUNT_W'(cnt + 1'b1);
                end
            end
        end

        // char field
        if (!done && ph == PH_SKIPC) begin
            done = 1'b1;
            if (i_ch == CH_NUL) begin
                acc = '0;
                ph  = PH_STOP;
            end else if (i_ch != CH_SPACE) begin
                chr = i_ch;
                cnt = COUNT_W'(cnt + 1'b1);
                ph  = PH_SKIPH;
            end
        end

        // skip spaces ahead of hex
        if (!done && ph == PH_SKIPH) begin
            if (i_ch == CH_SPACE) begin
                done = 1'b1;
            end else begin
                neg = 1'b0;
                dig = 1'b0;
                sz  = 1'b0;
                acc = '0;
                ph  = PH_HEX;
            end
        end

        // hex field with optional prefix
        if (!done && ph == PH_HEX) begin
            if ((i_ch == CH_LX || i_ch == CH_UX) && sz) begin
                sz  = 1'b0;
                dig = 1'b0;
                neg = 1'b1;
                acc = '0;
            end else if (is_hex) begin
                sz  = !dig && !neg && (i_ch == CH_ZERO);
                acc = (acc << 4) + VALUE_WIDTH'(hex_d);
                dig = 1'b1;
            end else if (dig) begin
                cnt = COUNT_W'(cnt + 1'b1);
                ph  = PH_STOP;
            end else begin
                acc = '0;
                ph  = PH_STOP;
            end
        end

        o_ctl.phase      = ph;
        o_ctl.neg        = neg;
        o_ctl.digit_seen = dig;
        o_ctl.saw_zero   = sz;
        o_accum          = acc;
        o_count          = cnt;
        o_first          = first;
        o_second         = second;
        o_char           = chr;
    end

endmodule

// ===== dv/int_int_char_hex_field_parser_top_tb.sv =====
// self-checking testbench for the decimal/decimal/char/hex text field parser
`timescale 1ns / 100ps

module int_int_char_hex_field_parser_top_tb;
    import iicfp_pkg::*;

    localparam int DEC_RADIX     = 10;
    localparam int HEX_RADIX     = 16;
    localparam int LETTER_BASE   = 10;
    localparam int ALL_FIELDS    = 4;
    localparam int RESET_CYCLES  = 12;
    localparam int BYTE_TARGET   = 1700;
    localparam int CALM_TAIL     = 200;
    localparam int IDLE_LIMIT    = 4000;
    localparam int DRAIN_CYCLES  = 10;
    localparam int REDO_LIMIT    = 8;

    // one parse result word
    typedef struct {
        logic [COUNT_W-1:0] count;
        logic [OUT_W-1:0]   first;
        logic [OUT_W-1:0]   second;
        logic [CH_W-1:0]    chr;
        logic [OUT_W-1:0]   hex;
    } t_parse_result;

    // parser prediction and result check
    class parse_scoreboard;
        logic [PHASE_W-1:0] phase;
        logic [OUT_W-1:0]   accum;
        bit                 neg;
        bit                 digit_seen;
        bit                 saw_zero;
        logic [OUT_W-1:0]   first_reg;
        logic [OUT_W-1:0]   second_reg;
        logic [CH_W-1:0]    char_reg;
        logic [COUNT_W-1:0] count_reg;
        t_parse_result      expected_q[$];
        int                 errors;
        int                 n_results;
        int                 n_full;

        function new();
            errors    = 0;
            n_results = 0;
            n_full    = 0;
            restart();
        endfunction

        function void clear_field();
            accum      = '0;
            neg        = 1'b0;
            digit_seen = 1'b0;
            saw_zero   = 1'b0;
        endfunction

        function void restart();
            phase      = PH_SKIP1;
            clear_field();
            first_reg  = '0;
            second_reg = '0;
            char_reg   = '0;
            count_reg  = '0;
        endfunction

        function void abandon();
            accum = '0;
            phase = PH_STOP;
        endfunction

        function logic [OUT_W-1:0] signed_value();
            return neg ? -accum : accum;
        endfunction

        function int hex_digit(logic [CH_W-1:0] c);
            if (c >= CH_ZERO && c <= CH_NINE) return int'(c - CH_ZERO);
            if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + LETTER_BASE;
            if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + LETTER_BASE;
            return -1;
        endfunction

        // one byte in the current phase; 1 means handle it again
        function bit take_byte(logic [CH_W-1:0] c);
            int d;
            case (phase)
                PH_SKIP1, PH_SKIP2: begin
                    if (c == CH_SPACE) return 1'b0;
                    clear_field();
                    phase = (phase == PH_SKIP1) ? PH_DEC1 : PH_DEC2;
                    return 1'b1;
                end
                PH_DEC1, PH_DEC2: begin
                    if (c == CH_MINUS && !neg && !digit_seen) begin
                        neg = 1'b1;
                        return 1'b0;
                    end
                    if (c >= CH_ZERO && c <= CH_NINE) begin
                        accum      = accum * DEC_RADIX + OUT_W'(c - CH_ZERO);
                        digit_seen = 1'b1;
                        return 1'b0;
                    end
                    if (!digit_seen) begin
                        abandon();
                        return 1'b0;
                    end
                    if (phase == PH_DEC1) begin
                        first_reg = signed_value();
                        phase     = PH_SKIP2;
                    end else begin
                        second_reg = signed_value();
                        phase      = PH_SKIPC;
                    end
                    count_reg++;
                    return 1'b1;
                end
                PH_SKIPC: begin
                    if (c == CH_SPACE) return 1'b0;
                    if (c == CH_NUL) begin
                        abandon();
                        return 1'b0;
                    end
                    char_reg = c;
                    count_reg++;
                    phase = PH_SKIPH;
                    return 1'b0;
                end
                PH_SKIPH: begin
                    if (c == CH_SPACE) return 1'b0;
                    clear_field();
                    phase = PH_HEX;
                    return 1'b1;
                end
                PH_HEX: begin
                    // prefix only right after a single leading zero
                    if ((c == CH_LX || c == CH_UX) && saw_zero) begin
                        saw_zero   = 1'b0;
                        digit_seen = 1'b0;
                        neg        = 1'b1;
                        accum      = '0;
                        return 1'b0;
                    end
                    d = hex_digit(c);
                    if (d >= 0) begin
                        saw_zero   = !digit_seen && !neg && c == CH_ZERO;
                        accum      = accum * HEX_RADIX + OUT_W'(d);
                        digit_seen = 1'b1;
                        return 1'b0;
                    end
                    if (digit_seen) begin
                        count_reg++;
                        phase = PH_STOP;
                    end else begin
                        abandon();
                    end
                    return 1'b0;
                end
                default: return 1'b0;
            endcase
        endfunction

        function void note_input(logic [CH_W-1:0] c);
            int            guard;
            t_parse_result r;
            guard = 0;
            while (guard < REDO_LIMIT && take_byte(c)) guard++;
            if (c == CH_NUL) begin
                r.count  = count_reg;
                r.first  = (count_reg >= 1) ? first_reg : '0;
                r.second = (count_reg >= 2) ? second_reg : '0;
                r.chr    = (count_reg >= 3) ? char_reg : '0;
                r.hex    = (count_reg >= ALL_FIELDS) ? accum : '0;
                expected_q.push_back(r);
                n_results++;
                if (count_reg == ALL_FIELDS) n_full++;
                restart();
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void compare(string name, logic [OUT_W-1:0] want, logic [OUT_W-1:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(t_parse_result got);
            t_parse_result want;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result: count %0d hex %h", $time, got.count, got.hex);
                return;
            end
            want = expected_q.pop_front();
            compare("field_count", OUT_W'(want.count), OUT_W'(got.count));
            compare("first_value", want.first, got.first);
            compare("second_value", want.second, got.second);
            compare("char_value", OUT_W'(want.chr), OUT_W'(got.chr));
            compare("hex_value", want.hex, got.hex);
        endfunction
    endclass

    logic                      i_clk   = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic [CH_W-1:0]           i_ch    = '0;
    logic                      i_ready = 1'b0;
    logic                      o_ready;
    logic                      o_valid;
    logic [COUNT_W-1:0]        o_field_count;
    logic signed [OUT_W-1:0]   o_first_value;
    logic signed [OUT_W-1:0]   o_second_value;
    logic [CH_W-1:0]           o_char_value;
    logic [OUT_W-1:0]          o_hex_value;

    parse_scoreboard sb = new();
    bit              idle_en = 1'b1;
    int              ready_hold = 0;
    int              n_bytes = 0;
    int              n_strings = 0;
    logic [CH_W-1:0] text_q[$];

    int_int_char_hex_field_parser_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_ch           (i_ch),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_field_count  (o_field_count),
        .o_first_value  (o_first_value),
        .o_second_value (o_second_value),
        .o_char_value   (o_char_value),
        .o_hex_value    (o_hex_value)
    );

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side back-pressure in bursts
    always @(posedge i_clk) begin
        if (!idle_en) begin
            i_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            i_ready    <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            ready_hold <= $urandom_range(0, 17);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // monitor both channels
    always @(posedge i_clk) begin
        t_parse_result got;
        if (i_rst_n) begin
            if (i_valid && o_ready) sb.note_input(i_ch);
            if (o_valid && i_ready) begin
                got.count  = o_field_count;
                got.first  = o_first_value;
                got.second = o_second_value;
                got.chr    = o_char_value;
                got.hex    = o_hex_value;
                sb.check_result(got);
            end
        end
    end

    // watchdog on cycles without any accepted word
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) quiet = 0;
            else quiet++;
        end
        $display("%0t watchdog: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // send one byte, with an optional gap before it
    task automatic send_byte(input logic [CH_W-1:0] c);
        if (idle_en && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ch    <= c;
        do @(posedge i_clk); while (!o_ready);
        n_bytes++;
    endtask

    task automatic send_text();
        foreach (text_q[i]) send_byte(text_q[i]);
        text_q.delete();
        n_strings++;
    endtask

    task automatic send_literal(input string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
        text_q.push_back(CH_NUL);
        send_text();
    endtask

    // hold the sender until every result is back
    task automatic wait_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic void push_str(string s);
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endfunction

    function automatic void add_spaces();
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) text_q.push_back(CH_SPACE);
    endfunction

    // decimal field: sign, short or overflowing digit runs, range edges
    function automatic void add_decimal();
        int sel;
        int nd;
        sel = $urandom_range(0, 15);
        if ($urandom_range(0, 2) == 0) text_q.push_back(CH_MINUS);
        if (sel == 3) begin
            push_str($urandom_range(0, 1) ? "2147483648" : "4294967295");
        end else begin
            nd = (sel == 0) ? 0 : (sel <= 2) ? $urandom_range(10, 12) : $urandom_range(1, 5);
            repeat (nd) text_q.push_back(CH_ZERO + CH_W'($urandom_range(0, 9)));
        end
        // separator, occasionally missing or odd
        case ($urandom_range(0, 7))
            0:       ;
            1:       text_q.push_back(CH_MINUS);
            2:       text_q.push_back(CH_W'($urandom_range(1, 255)));
            default: text_q.push_back(CH_SPACE);
        endcase
    endfunction

    // hex field: optional prefix, mixed case digits, late prefix, overflow
    function automatic void add_hex();
        int sel;
        int nd;
        int v;
        sel = $urandom_range(0, 11);
        case ($urandom_range(0, 3))
            1:       push_str("0x");
            2:       push_str("0X");
            default: ;
        endcase
        if (sel == 3) begin
            push_str("00x");
        end else if (sel == 4) begin
            push_str($urandom_range(0, 1) ? "ffffffff" : "FFFFFFFF");
        end else if (sel == 5) begin
            text_q.push_back(CH_ZERO);
        end
        nd = (sel == 0) ? 0 : (sel <= 2) ? $urandom_range(9, 10) : $urandom_range(1, 6);
        repeat (nd) begin
            v = $urandom_range(0, 21);
            if (v < DEC_RADIX) text_q.push_back(CH_ZERO + CH_W'(v));
            else if (v < HEX_RADIX) text_q.push_back(CH_LA + CH_W'(v - DEC_RADIX));
            else text_q.push_back(CH_UA + CH_W'(v - HEX_RADIX));
        end
    endfunction

    // one random string: mostly well-formed, some cut short, some noise
    function automatic void build_string();
        int kind;
        int cut;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(1, 10)) text_q.push_back(CH_W'($urandom_range(1, 255)));
        end else begin
            cut = (kind == 1) ? $urandom_range(0, 3) : ALL_FIELDS;
            add_spaces();
            if (cut > 0) add_decimal();
            add_spaces();
            if (cut > 1) add_decimal();
            add_spaces();
            if (cut > 2) text_q.push_back(CH_W'($urandom_range(1, 255)));
            add_spaces();
            if (cut > 3) add_hex();
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) text_q.push_back(CH_W'($urandom_range(1, 255)));
        end
        text_q.push_back(CH_NUL);
    endfunction

    // main sequence
    initial begin
        bit paused;
        paused = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed strings
        send_literal("");
        send_literal("-5-");
        send_literal("9 9\37700x");
        send_literal("1 2");
        send_literal("0 0c0X");

        // random strings in stretches with and without idling
        while (n_bytes < BYTE_TARGET) begin
            if (n_bytes > BYTE_TARGET - CALM_TAIL) idle_en = 1'b0;
            else idle_en = ($urandom_range(0, 3) != 0);
            if (!paused && n_bytes > BYTE_TARGET / 2) begin
                wait_results();
                paused = 1'b1;
            end
            build_string();
            send_text();
        end
        wait_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d bytes in %0d strings, %0d results checked",
                 n_bytes, n_strings, sb.n_results);
        $display("%0d results carried all four fields, the rest failed or ended early",
                 sb.n_full);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/iicfp_pkg.sv
rtl/core/iicfp_step.sv
rtl/core/int_int_char_hex_field_parser_top.sv
dv/int_int_char_hex_field_parser_top_tb.sv
